// ----- rtl/core/sfd_pkg.sv -----
// Shared types and constants for the SLIP frame decoder.
// Holds the framing symbols, result kind and error codes, and the result record.
// No dependencies.
package sfd_pkg;

    // Framing symbols on the wire
    localparam logic [7:0] SYM_START     = 8'hAB;
    localparam logic [7:0] SYM_END       = 8'hBC;
    localparam logic [7:0] SYM_ESC       = 8'hCD;
    localparam logic [7:0] SYM_ESC_START = 8'hAC;
    localparam logic [7:0] SYM_ESC_END   = 8'hBD;
    localparam logic [7:0] SYM_ESC_ESC   = 8'hCE;

    // Shortest frame accepted at the end byte
    localparam int unsigned MIN_FRAME = 6;

    localparam int unsigned LEN_W = 11;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_GOOD  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_LONG   = 2'd2;
    localparam logic [1:0] ERR_SHORT  = 2'd3;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [1:0]       kind;
        logic [1:0]       error_code;
        logic [LEN_W-1:0] frame_length;
    } result_t;

    // One decoded result with its valid flag, from decoder to output register
    typedef struct packed {
        logic    valid;
        result_t res;
    } result_slot_t;

endpackage

// ----- rtl/core/sfd_in_reg.sv -----
// Input register of the SLIP frame decoder: holds one raw byte for the decode step.
// Depends on nothing but its ports.
module sfd_in_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       advance,     // decode step consumes the held byte
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // Take a new byte when empty or when the held one moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ----- rtl/core/sfd_decode.sv -----
// Decode step of the SLIP frame decoder: framing state and one-byte deframing logic.
// Depends on sfd_pkg for symbols, codes and the result record.
module sfd_decode
#(
    parameter int unsigned MAX_FRAME = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,       // process the held byte this cycle
    input  logic [7:0]           cur_byte,
    output sfd_pkg::result_slot_t slot
);
    import sfd_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_FRAME);

    logic             inside_frame_reg,   inside_frame_next;
    logic             escape_pending_reg, escape_pending_next;
    logic [CNT_W-1:0] decoded_count_reg,  decoded_count_next;

    logic             emit;
    logic [7:0]       emit_val;
    logic             abort;
    logic [1:0]       abort_err;
    logic             good_end;
    logic [CNT_W+LEN_W-1:0] count_ext;
    logic [LEN_W-1:0] count_len;

    assign count_ext = {{LEN_W{1'b0}}, decoded_count_reg};
    assign count_len = count_ext[LEN_W-1:0];

    // Classify the byte against the framing state
    always_comb
    begin
        emit                = 1'b0;
        emit_val            = cur_byte;
        abort               = 1'b0;
        abort_err           = ERR_NONE;
        good_end            = 1'b0;
        inside_frame_next   = inside_frame_reg;
        escape_pending_next = escape_pending_reg;
        decoded_count_next  = decoded_count_reg;

        priority if (!inside_frame_reg)
        begin
            if (cur_byte == SYM_START)
            begin
                inside_frame_next   = 1'b1;
                escape_pending_next = 1'b0;
                decoded_count_next  = '0;
            end
        end
        else if (escape_pending_reg)
        begin
            escape_pending_next = 1'b0;
            priority if (cur_byte == SYM_ESC_START)
            begin
                emit     = 1'b1;
                emit_val = SYM_START;
            end
            else if (cur_byte == SYM_ESC_END)
            begin
                emit     = 1'b1;
                emit_val = SYM_END;
            end
            else if (cur_byte == SYM_ESC_ESC)
            begin
                emit     = 1'b1;
                emit_val = SYM_ESC;
            end
            else
            begin
                abort     = 1'b1;
                abort_err = ERR_ESCAPE;
            end
        end
        else if (cur_byte == SYM_START)
        begin
            // start byte inside a frame: ignore
        end
        else if (cur_byte == SYM_ESC)
        begin
            escape_pending_next = 1'b1;
        end
        else if (cur_byte == SYM_END)
        begin
            if (decoded_count_reg < MIN_CNT)
            begin
                abort     = 1'b1;
                abort_err = ERR_SHORT;
            end
            else
            begin
                good_end = 1'b1;
            end
        end
        else
        begin
            emit = 1'b1;
        end

        // A data byte past the length limit aborts the frame instead
        if (emit && (decoded_count_reg >= MAX_CNT))
        begin
            emit      = 1'b0;
            abort     = 1'b1;
            abort_err = ERR_LONG;
        end

        if (emit)
        begin
            decoded_count_next = decoded_count_reg + 1'b1;
        end

        if (abort || good_end)
        begin
            inside_frame_next   = 1'b0;
            escape_pending_next = 1'b0;
            decoded_count_next  = '0;
        end
    end

    // Build the result record
    always_comb
    begin
        slot.valid                = step && (emit || abort || good_end);
        slot.res.data_byte        = 8'd0;
        slot.res.kind             = KIND_DATA;
        slot.res.error_code       = ERR_NONE;
        slot.res.frame_length     = '0;
        priority if (emit)
        begin
            slot.res.data_byte    = emit_val;
        end
        else if (abort)
        begin
            slot.res.kind         = KIND_ERROR;
            slot.res.error_code   = abort_err;
            slot.res.frame_length = count_len;
        end
        else if (good_end)
        begin
            slot.res.kind         = KIND_GOOD;
            slot.res.frame_length = count_len;
        end
        else
        begin
            slot.res.data_byte    = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_frame_reg   <= 1'b0;
            escape_pending_reg <= 1'b0;
            decoded_count_reg  <= '0;
        end
        else if (step)
        begin
            inside_frame_reg   <= inside_frame_next;
            escape_pending_reg <= escape_pending_next;
            decoded_count_reg  <= decoded_count_next;
        end
    end

endmodule

// ----- rtl/core/sfd_out_reg.sv -----
// Output register of the SLIP frame decoder: holds one result until the sink takes it.
// Depends on sfd_pkg for the result record.
module sfd_out_reg
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfd_pkg::result_slot_t slot,
    output logic                  load_ok,   // register is free or draining this cycle
    output logic                  out_valid,
    input  logic                  out_ready,
    output sfd_pkg::result_t      out_res
);
    import sfd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign load_ok = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            valid_reg <= slot.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && slot.valid)
        begin
            res_reg <= slot.res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- rtl/core/slip_frame_decoder.sv -----
// Top level of the SLIP frame decoder: input register, decode step, output register.
// Depends on sfd_pkg, sfd_in_reg, sfd_decode and sfd_out_reg.
//
// Usage:
//   Raw serial bytes enter on the s_axis channel, one byte per transfer.
//   Bytes outside a frame are dropped until the start byte 0xAB. Inside a
//   frame, escapes (0xCD then 0xAC/0xBD/0xCE) are decoded and each decoded
//   byte leaves on m_axis with tuser kind = data. The end byte 0xBC yields a
//   frame-good result carrying the decoded length; a short frame (under six
//   bytes), a bad escape or a frame over MAX_FRAME bytes yields an error
//   result with its code and the count so far, then the block hunts again.
//   Path: each byte is held in the input register, decoded, and its result
//   is registered in the output register before it is offered on m_axis.
//   Throughput: one byte per cycle while the sink does not stall, set by
//   the state update in the decode step; bytes that make no result are
//   still consumed by a decode step.
//   Reset clears the framing state (hunting, no escape, count zero) and
//   empties both registers. When the sink stalls, the output register holds
//   its result, the input register holds one byte, and s_axis_tready drops.
module slip_frame_decoder
#(
    parameter int unsigned MAX_FRAME = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [9:8] error_code,
                                        // [20:10] frame_length, [23:21] zero
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);
    import sfd_pkg::*;

    logic         held_valid;
    logic [7:0]   held_byte;
    logic         load_ok;
    logic         step;
    result_slot_t slot;
    result_t      out_res;

    // Advance the held byte whenever the output register can take its result
    assign step = held_valid && load_ok;

    sfd_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .advance    (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sfd_decode #(
        .MAX_FRAME (MAX_FRAME)
    ) u_decode
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cur_byte (held_byte),
        .slot     (slot)
    );

    sfd_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .slot      (slot),
        .load_ok   (load_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {3'b000, out_res.frame_length, out_res.error_code, out_res.data_byte};
    assign m_axis_tuser = out_res.kind;

endmodule
